[hdl/weighted_kmeans_clustering_assert.svh]
// assertion macros shared by the weighted k-means engine
`ifndef WEIGHTED_KMEANS_CLUSTERING_ASSERT_SVH
`define WEIGHTED_KMEANS_CLUSTERING_ASSERT_SVH

// property that must hold on every clock edge outside reset
`define WKM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define WKM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[hdl/wkm_pkg.sv]
// shared types and codes of the weighted k-means engine
package wkm_pkg;

    // input commands
    localparam logic [1:0] CMD_LOAD_CENTER = 2'd0;
    localparam logic [1:0] CMD_LOAD_POINT  = 2'd1;
    localparam logic [1:0] CMD_RUN         = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DIMS   = 2'd0;
    localparam logic [1:0] REG_POINTS = 2'd1;
    localparam logic [1:0] REG_ROUNDS = 2'd2;

    // arithmetic widths
    localparam int SUM_W  = 48;
    localparam int WSUM_W = 32;
    localparam int DIST_W = 37;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_DRD,
        S_DACC,
        S_DCMP,
        S_SEL,
        S_ARD,
        S_AACC,
        S_UPD,
        S_DIV,
        S_ELOAD,
        S_EWAIT
    } t_state;

    // effective run settings
    typedef struct packed {
        logic [2:0]  dim_last;
        logic [15:0] pt_last;
        logic [7:0]  round_last;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic        load_center;
        logic        load_point;
        logic        clr_sums;
        logic        dist_acc;
        logic        dist_cmp;
        logic        first_cl;
        logic        acc_add;
        logic        add_weight;
        logic        div_start;
        logic        emit_load;
        logic        emit_clear;
        logic        emit_last;
        logic [2:0]  cl;
        logic [2:0]  dim;
        logic [15:0] pt;
    } t_ctl;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] best;
        logic       wsum_zero;
        logic       div_done;
    } t_sts;

endpackage

[hdl/wkm_div.sv]
// iterative signed by unsigned divider with truncation and 16-bit saturation
module wkm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wkm_pkg::SUM_W-1:0]      i_num,
    input  logic [wkm_pkg::WSUM_W-1:0]     i_den,
    output logic                           o_done,
    output logic signed [15:0]             o_quo
);
    localparam int NW = wkm_pkg::SUM_W;
    localparam int DW = wkm_pkg::WSUM_W;
    localparam logic [5:0] STEP_LAST = 6'(NW - 1);

    logic          r_busy, r_fin, r_done, r_neg;
    logic [5:0]    r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem, r_den;
    logic [15:0]   r_q;
    logic [DW:0]   n_trial;
    logic          n_fit;
    logic [15:0]   n_sat;

    // one quotient bit per cycle
    always_comb begin
        n_trial = {r_rem, r_quo[NW-1]};
        n_fit   = n_trial >= {1'b0, r_den};
    end

    // saturate the magnitude and apply the sign
    always_comb begin
        if (!r_neg) begin
            n_sat = (|r_quo[NW-1:15]) ? 16'h7FFF : r_quo[15:0];
        end else if ((|r_quo[NW-1:16]) || (r_quo[15] && (|r_quo[14:0]))) begin
            n_sat = 16'h8000;
        end else begin
            n_sat = 16'(-r_quo[15:0]);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NW-1];
            r_quo <= i_num[NW-1] ? NW'(-i_num) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_fit ? DW'(n_trial - {1'b0, r_den}) : n_trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], n_fit};
        end
        if (r_fin) begin
            r_q <= n_sat;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

[hdl/wkm_dp.sv]
// datapath: stores, distance and sum accumulation, center update, result register
module wkm_dp #(
    parameter int CLUSTERS   = 4,
    parameter int MAX_DIMS   = 8,
    parameter int MAX_POINTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wkm_pkg::t_ctl      i_ctl,
    output wkm_pkg::t_sts      o_sts,
    input  logic [9:0]         i_entry_index,
    input  logic [2:0]         i_coord_index,
    input  logic signed [15:0] i_coord_value,
    input  logic [15:0]        i_point_weight,
    output logic               o_valid,
    output logic [2:0]         o_center_index,
    output logic [2:0]         o_coord_index,
    output logic signed [15:0] o_center_value,
    output logic               o_last
);
    localparam int CN  = CLUSTERS * MAX_DIMS;
    localparam int PN  = MAX_POINTS * MAX_DIMS;
    localparam int CAW = (CN > 1) ? $clog2(CN) : 1;
    localparam int PAW = $clog2(PN);
    localparam int WAW = $clog2(MAX_POINTS);
    localparam int CLW = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int SW  = wkm_pkg::SUM_W;
    localparam int WSW = wkm_pkg::WSUM_W;
    localparam int DSW = wkm_pkg::DIST_W;

    logic signed [15:0] r_center [CN];
    logic [15:0]        r_pmem   [PN];
    logic [15:0]        r_wmem   [MAX_POINTS];
    logic [SW-1:0]      r_csum   [CN];
    logic [WSW-1:0]     r_wsum   [CLUSTERS];
    logic signed [15:0] r_pt_q;
    logic [15:0]        r_w_q;
    logic [DSW-1:0]     r_dist, r_best_d;
    logic [2:0]         r_best;
    logic               r_ovalid, r_olast;
    logic [2:0]         r_ocl, r_odim;
    logic signed [15:0] r_oval;

    logic [31:0]        n_ca_full, n_pr_full, n_pw_full;
    logic [CAW-1:0]     n_ca;
    logic [PAW-1:0]     n_pr, n_pw;
    logic [CLW-1:0]     n_cl;
    logic signed [16:0] n_diff;
    logic signed [33:0] n_sq;
    logic signed [32:0] n_prod;
    logic               n_c_ok, n_p_ok, n_div_done;
    logic signed [15:0] n_quo;

    // address arithmetic
    always_comb begin
        n_ca_full = 32'(i_ctl.cl) * MAX_DIMS + 32'(i_ctl.dim);
        n_pr_full = 32'(i_ctl.pt) * MAX_DIMS + 32'(i_ctl.dim);
        n_pw_full = 32'(i_entry_index) * MAX_DIMS + 32'(i_coord_index);
        n_ca      = n_ca_full[CAW-1:0];
        n_pr      = n_pr_full[PAW-1:0];
        n_pw      = n_pw_full[PAW-1:0];
        n_cl      = i_ctl.cl[CLW-1:0];
        n_c_ok    = (32'(i_entry_index) < CLUSTERS) && (32'(i_coord_index) < MAX_DIMS);
        n_p_ok    = (32'(i_entry_index) < MAX_POINTS) && (32'(i_coord_index) < MAX_DIMS);
    end

    // point and weight memories
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_point && n_p_ok) begin
            r_pmem[n_pw] <= i_coord_value;
            r_wmem[WAW'(i_entry_index)] <= i_point_weight;
        end
        r_pt_q <= r_pmem[n_pr];
        r_w_q  <= r_wmem[i_ctl.pt[WAW-1:0]];
    end

    // distance term and weighted coordinate
    always_comb begin
        n_diff = 17'(r_pt_q) - 17'(r_center[n_ca]);
        n_sq   = n_diff * n_diff;
        n_prod = 33'(r_pt_q) * $signed({17'd0, r_w_q});
    end

    // nearest center search
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_sums) begin
            r_dist <= '0;
        end else if (i_ctl.dist_acc) begin
            r_dist <= r_dist + DSW'(n_sq[33:0]);
        end else if (i_ctl.dist_cmp) begin
            r_dist <= '0;
            if (i_ctl.first_cl || (r_dist < r_best_d)) begin
                r_best_d <= r_dist;
                r_best   <= i_ctl.cl;
            end
        end
    end

    // cluster sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_sums) begin
            for (int k = 0; k < CN; k++) begin
                r_csum[k] <= '0;
            end
            for (int k = 0; k < CLUSTERS; k++) begin
                r_wsum[k] <= '0;
            end
        end else if (i_ctl.acc_add) begin
            r_csum[n_ca] <= r_csum[n_ca] + SW'(n_prod);
            if (i_ctl.add_weight) begin
                r_wsum[n_cl] <= r_wsum[n_cl] + WSW'(r_w_q);
            end
        end
    end

    wkm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (r_csum[n_ca]),
        .i_den   (r_wsum[n_cl]),
        .o_done  (n_div_done),
        .o_quo   (n_quo)
    );

    // center store: loads and updates
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_center && n_c_ok) begin
            r_center[n_pw_full[CAW-1:0]] <= i_coord_value;
        end else if (n_div_done) begin
            r_center[n_ca] <= n_quo;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.emit_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ctl.emit_clear) begin
            r_ovalid <= 1'b0;
        end
        if (i_ctl.emit_load) begin
            r_ocl   <= i_ctl.cl;
            r_odim  <= i_ctl.dim;
            r_oval  <= r_center[n_ca];
            r_olast <= i_ctl.emit_last;
        end
    end

    always_comb begin
        o_sts.best      = r_best;
        o_sts.wsum_zero = (r_wsum[n_cl] == '0);
        o_sts.div_done  = n_div_done;
    end

    assign o_valid        = r_ovalid;
    assign o_center_index = r_ocl;
    assign o_coord_index  = r_odim;
    assign o_center_value = r_oval;
    assign o_last         = r_olast;
endmodule

[hdl/wkm_ctrl.sv]
// controller: sequences loads, rounds, center updates and result emission
module wkm_ctrl #(
    parameter int CLUSTERS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wkm_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    input  logic [1:0]    i_command,
    output logic          o_in_stall,
    input  logic          i_out_accept,
    input  wkm_pkg::t_sts i_sts,
    output wkm_pkg::t_ctl o_ctl
);
    localparam logic [2:0] CL_LAST = 3'(CLUSTERS - 1);

    wkm_pkg::t_state r_state, n_state;
    logic [2:0]  r_cl, r_dim;
    logic [15:0] r_pt;
    logic [7:0]  r_rnd;
    logic        n_acc, n_dim_end, n_cl_end, n_pt_end, n_upd_adv, n_upd_end;

    always_comb begin
        n_acc     = i_in_valid && !o_in_stall;
        n_dim_end = (r_dim == i_cfg.dim_last);
        n_cl_end  = (r_cl == CL_LAST);
        n_pt_end  = (r_pt == i_cfg.pt_last);
        n_upd_adv = ((r_state == wkm_pkg::S_UPD) && i_sts.wsum_zero)
                 || ((r_state == wkm_pkg::S_DIV) && i_sts.div_done);
        n_upd_end = n_dim_end && n_cl_end;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            wkm_pkg::S_IDLE: begin
                if (n_acc && (i_command == wkm_pkg::CMD_RUN)) n_state = wkm_pkg::S_CLR;
            end
            wkm_pkg::S_CLR:  n_state = wkm_pkg::S_DRD;
            wkm_pkg::S_DRD:  n_state = wkm_pkg::S_DACC;
            wkm_pkg::S_DACC: n_state = n_dim_end ? wkm_pkg::S_DCMP : wkm_pkg::S_DRD;
            wkm_pkg::S_DCMP: n_state = n_cl_end ? wkm_pkg::S_SEL : wkm_pkg::S_DRD;
            wkm_pkg::S_SEL:  n_state = wkm_pkg::S_ARD;
            wkm_pkg::S_ARD:  n_state = wkm_pkg::S_AACC;
            wkm_pkg::S_AACC: begin
                if (!n_dim_end)    n_state = wkm_pkg::S_ARD;
                else if (n_pt_end) n_state = wkm_pkg::S_UPD;
                else               n_state = wkm_pkg::S_DRD;
            end
            wkm_pkg::S_UPD, wkm_pkg::S_DIV: begin
                if (r_state == wkm_pkg::S_UPD && !i_sts.wsum_zero) begin
                    n_state = wkm_pkg::S_DIV;
                end else if (n_upd_adv) begin
                    if (!n_upd_end)                       n_state = wkm_pkg::S_UPD;
                    else if (r_rnd == i_cfg.round_last)  n_state = wkm_pkg::S_ELOAD;
                    else                                  n_state = wkm_pkg::S_CLR;
                end
            end
            wkm_pkg::S_ELOAD: n_state = wkm_pkg::S_EWAIT;
            wkm_pkg::S_EWAIT: begin
                if (i_out_accept) n_state = n_upd_end ? wkm_pkg::S_IDLE : wkm_pkg::S_ELOAD;
            end
            default: n_state = wkm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall        = (r_state != wkm_pkg::S_IDLE);
        o_ctl             = '0;
        o_ctl.cl          = r_cl;
        o_ctl.dim         = r_dim;
        o_ctl.pt          = r_pt;
        o_ctl.first_cl    = (r_cl == 3'd0);
        o_ctl.add_weight  = (r_dim == 3'd0);
        o_ctl.emit_last   = n_upd_end;
        unique case (r_state)
            wkm_pkg::S_IDLE: begin
                o_ctl.load_center = n_acc && (i_command == wkm_pkg::CMD_LOAD_CENTER);
                o_ctl.load_point  = n_acc && (i_command == wkm_pkg::CMD_LOAD_POINT);
            end
            wkm_pkg::S_CLR:   o_ctl.clr_sums   = 1'b1;
            wkm_pkg::S_DACC:  o_ctl.dist_acc   = 1'b1;
            wkm_pkg::S_DCMP:  o_ctl.dist_cmp   = 1'b1;
            wkm_pkg::S_AACC:  o_ctl.acc_add    = 1'b1;
            wkm_pkg::S_UPD:   o_ctl.div_start  = !i_sts.wsum_zero;
            wkm_pkg::S_ELOAD: o_ctl.emit_load  = 1'b1;
            wkm_pkg::S_EWAIT: o_ctl.emit_clear = i_out_accept;
            default: ;
        endcase
    end

    // state and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wkm_pkg::S_IDLE;
            r_cl    <= '0;
            r_dim   <= '0;
            r_pt    <= '0;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state) inside
                wkm_pkg::S_IDLE: r_rnd <= '0;
                wkm_pkg::S_CLR: begin
                    r_cl  <= '0;
                    r_dim <= '0;
                    r_pt  <= '0;
                end
                wkm_pkg::S_DACC: r_dim <= n_dim_end ? 3'd0 : r_dim + 3'd1;
                wkm_pkg::S_DCMP: begin
                    if (!n_cl_end) r_cl <= r_cl + 3'd1;
                end
                wkm_pkg::S_SEL: begin
                    r_cl  <= i_sts.best;
                    r_dim <= '0;
                end
                wkm_pkg::S_AACC: begin
                    if (n_dim_end) begin
                        r_dim <= '0;
                        r_cl  <= '0;
                        if (!n_pt_end) r_pt <= r_pt + 16'd1;
                    end else begin
                        r_dim <= r_dim + 3'd1;
                    end
                end
                wkm_pkg::S_UPD, wkm_pkg::S_DIV, wkm_pkg::S_EWAIT: begin
                    if (n_upd_adv || (r_state == wkm_pkg::S_EWAIT && i_out_accept)) begin
                        if (n_dim_end) begin
                            r_dim <= '0;
                            r_cl  <= n_cl_end ? 3'd0 : r_cl + 3'd1;
                            if (n_upd_end && r_state != wkm_pkg::S_EWAIT) begin
                                r_rnd <= r_rnd + 8'd1;
                            end
                        end else begin
                            r_dim <= r_dim + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[hdl/weighted_kmeans_clustering.sv]
// Weighted k-means engine top level: configuration registers, controller and datapath.
// Load commands (center or point coordinate) are taken one per cycle while idle. A run
// command stalls the input until its results are out. Each round starts with a clear step,
// then per point a distance walk (for each cluster and coordinate, one read from the point
// memory, then one squared difference), CLUSTERS compares, a select step and the weighted
// sums (one read and one accumulate per coordinate); per non-empty cluster coordinate the
// update runs through the bit-serial divider, and an empty cluster keeps its center. D is
// the effective dims_in_use. Each result is held until accepted; CLUSTERS*D per run, center
// major, last marking the final one. Stores hold garbage until loaded; no clearing pass.
module weighted_kmeans_clustering #(
    parameter int CLUSTERS   = 4,
    parameter int MAX_DIMS   = 8,
    parameter int MAX_POINTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [9:0]         i_entry_index,
    input  logic [2:0]         i_coord_index,
    input  logic signed [15:0] i_coord_value,
    input  logic [15:0]        i_point_weight,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_center_index,
    output logic [2:0]         o_out_coord_index,
    output logic signed [15:0] o_center_value,
    output logic               o_last
);
    `include "weighted_kmeans_clustering_assert.svh"

    logic [3:0]    r_dims;
    logic [10:0]   r_npts;
    logic [7:0]    r_rounds;
    wkm_pkg::t_cfg n_cfg;
    wkm_pkg::t_ctl n_ctl;
    wkm_pkg::t_sts n_sts;
    logic          n_out_acc;
    int            n_d, n_p;

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= 4'd8;
            r_npts   <= 11'd1024;
            r_rounds <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wkm_pkg::REG_DIMS:   r_dims   <= i_cfg_data[3:0];
                wkm_pkg::REG_POINTS: r_npts   <= i_cfg_data;
                wkm_pkg::REG_ROUNDS: r_rounds <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clamp settings to usable ranges
    always_comb begin
        n_d = (r_dims == 4'd0) ? 1 : ((32'(r_dims) > MAX_DIMS) ? MAX_DIMS : 32'(r_dims));
        n_p = (r_npts == 11'd0) ? 1 : ((32'(r_npts) > MAX_POINTS) ? MAX_POINTS : 32'(r_npts));
        n_cfg.dim_last   = 3'(n_d - 1);
        n_cfg.pt_last    = 16'(n_p - 1);
        n_cfg.round_last = (r_rounds == 8'd0) ? 8'd0 : r_rounds - 8'd1;
    end

    assign n_out_acc = o_out_valid && !i_out_stall;

    wkm_ctrl #(.CLUSTERS(CLUSTERS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (n_cfg),
        .i_in_valid   (i_in_valid),
        .i_command    (i_command),
        .o_in_stall   (o_in_stall),
        .i_out_accept (n_out_acc),
        .i_sts        (n_sts),
        .o_ctl        (n_ctl)
    );

    wkm_dp #(
        .CLUSTERS   (CLUSTERS),
        .MAX_DIMS   (MAX_DIMS),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (n_ctl),
        .o_sts          (n_sts),
        .i_entry_index  (i_entry_index),
        .i_coord_index  (i_coord_index),
        .i_coord_value  (i_coord_value),
        .i_point_weight (i_point_weight),
        .o_valid        (o_out_valid),
        .o_center_index (o_center_index),
        .o_coord_index  (o_out_coord_index),
        .o_center_value (o_center_value),
        .o_last         (o_last)
    );

    // no input transfer while a result is pending
    `WKM_NEVER(a_no_in_during_out, (i_in_valid && !o_in_stall && o_out_valid), "input taken during emit")
    // the final result ends the emission
    `WKM_ASSERT(a_last_ends, (n_out_acc && o_last) |=> !o_out_valid, "result after last")
    // emitted cluster index stays in range
    `WKM_ASSERT(a_cl_range, o_out_valid |-> (32'(o_center_index) < CLUSTERS), "cluster out of range")
endmodule
